### sv/set_assoc_cache_lru_tags_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU tag store
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_TAGS_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define SACL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SACL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Types, codes and width helpers for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

   // Default geometry
   localparam int DEF_WAYS       = 8;
   localparam int DEF_SETS       = 1024;
   localparam int DEF_ADDR_WIDTH = 32;

   // Fixed field widths
   localparam int FIELD_W   = 32;
   localparam int CSR_W     = 4;
   localparam int CSR_IDX_W = 2;
   // widest set index a 4-bit set_index_bits can ask for
   localparam int IDX_W     = (2 ** CSR_W) - 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_INDEX_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE    = 2'd2;

   // Register reset values
   localparam logic [CSR_W-1:0] RST_SET_INDEX_BITS = 4'd10;
   localparam logic [CSR_W-1:0] RST_OFFSET_BITS    = 4'd6;
   localparam logic [CSR_W-1:0] RST_WAYS_IN_USE    = 4'd8;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      OUT_RD_HIT   = 3'd0,
      OUT_RD_MISS  = 3'd1,
      OUT_WR_HIT   = 3'd2,
      OUT_WR_MISS  = 3'd3,
      OUT_WR_EVICT = 3'd4
   } outcome_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CALC
   } state_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [FIELD_W-1:0]   address;
   } req_type;

   typedef struct packed {
      outcome_type          outcome;
      logic [FIELD_W-1:0]   line_tag;
      logic                 line_valid;
   } rsp_type;

   typedef struct packed {
      logic [CSR_W-1:0]     set_index_bits;
      logic [CSR_W-1:0]     offset_bits;
      logic [CSR_W-1:0]     ways_in_use;
   } cfg_type;

   // Stored tag width: the address is cut to addr_w bits, at most FIELD_W
   function automatic int tag_width(int addr_w);
      return (addr_w < FIELD_W) ? addr_w : FIELD_W;
   endfunction

   // Bits to address n entries, at least one
   function automatic int index_width(int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

### sv/set_assoc_cache_lru_tags.sv
// Set-associative tag store with LRU replacement.
// req_*: one beat per access (cmd read or write, byte address), valid/ready.
// rsp_*: one beat per access (outcome, line tag, line valid), valid/ready.
// csr_*: register writes (index 0 set_index_bits, 1 offset_bits,
//        2 ways_in_use); always ready. The user must write them only while
//        no access is in flight; the block does not enforce it.
// Each set lives in one RAM row; an access reads the row, compares all ways
// and updates the LRU ranks in the next cycle, then writes the row back.
// Accesses are serialised by the row read-modify-write on the single RAM; a
// new request is taken in the write-back cycle.
// Reset: control and registers go to their reset values, then a clearing
// pass writes every row empty, with req_ready low throughout.
// Stall: the result sits in an output register; while it is not taken the
// block finishes the current row only when the register frees up.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags
// Top level: configuration registers, sequencer, set RAM and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_tags #(
   parameter int WAYS       = sacl_pkg::DEF_WAYS,
   parameter int SETS       = sacl_pkg::DEF_SETS,
   parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire sacl_pkg::req_type                    req_data,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      sacl_pkg::rsp_type                    rsp_data,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [sacl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sacl_pkg::CSR_W-1:0]           csr_data
);

   localparam int TW      = sacl_pkg::tag_width(ADDR_WIDTH);
   localparam int SW      = sacl_pkg::index_width(SETS);
   localparam int RKW     = sacl_pkg::index_width(WAYS);
   localparam int TAG_LO  = 0;
   localparam int VAL_LO  = TAG_LO + WAYS * TW;
   localparam int OCC_LO  = VAL_LO + WAYS;
   localparam int RANK_LO = OCC_LO + WAYS;
   localparam int ROWW    = RANK_LO + WAYS * RKW;

   sacl_pkg::state_type       state_ff;
   sacl_pkg::state_type       state_in;
   sacl_pkg::cfg_type         cfg_ff;
   sacl_pkg::cfg_type         cfg_in;
   logic [SW-1:0]             clr_ff;
   logic [SW-1:0]             clr_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   sacl_pkg::rsp_type         rsp_data_ff;
   sacl_pkg::rsp_type         rsp_data_in;

   logic                      req_fire;
   logic                      out_free;
   logic                      clr_last;
   logic                      rd_en;
   logic                      wr_en;
   logic                      rsp_load;
   logic                      clearing;

   sacl_pkg::cmd_type         acc_cmd;
   logic [TW-1:0]             acc_tag;
   logic [SW-1:0]             acc_set;

   logic [ROWW-1:0]           row_rd;
   logic [ROWW-1:0]           row_wr;
   logic [SW-1:0]             wr_addr;
   logic [ROWW-1:0]           wr_data;

   logic [WAYS-1:0][TW-1:0]   cur_tag;
   logic [WAYS-1:0]           cur_valid;
   logic [WAYS-1:0]           cur_occ;
   logic [WAYS-1:0][RKW-1:0]  cur_rank;
   logic [WAYS-1:0][TW-1:0]   nxt_tag;
   logic [WAYS-1:0]           nxt_valid;
   logic [WAYS-1:0]           nxt_occ;
   logic [WAYS-1:0][RKW-1:0]  nxt_rank;
   sacl_pkg::rsp_type         way_rsp;

   // Handshake helpers
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign clr_last  = (clr_ff == SW'(SETS - 1));
   assign csr_ready = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sacl_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = sacl_pkg::ST_IDLE;
            end
         end
         sacl_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = sacl_pkg::ST_READ;
            end
         end
         sacl_pkg::ST_READ: begin
            state_in = sacl_pkg::ST_CALC;
         end
         sacl_pkg::ST_CALC: begin
            if (out_free) begin
               state_in = req_fire ? sacl_pkg::ST_READ : sacl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sacl_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      clearing  = 1'b0;
      unique case (state_ff)
         sacl_pkg::ST_CLEAR: begin
            clearing = 1'b1;
            wr_en    = 1'b1;
         end
         sacl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         sacl_pkg::ST_READ: begin
            rd_en = 1'b1;
         end
         sacl_pkg::ST_CALC: begin
            req_ready = out_free;
            wr_en     = out_free;
            rsp_load  = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Advance the clearing sweep
   always_comb begin
      clr_in = clr_ff;
      if (clearing && !clr_last) begin
         clr_in = clr_ff + 1'b1;
      end
   end

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sacl_pkg::CSR_SET_INDEX_BITS: cfg_in.set_index_bits = csr_data;
            sacl_pkg::CSR_OFFSET_BITS:    cfg_in.offset_bits    = csr_data;
            sacl_pkg::CSR_WAYS_IN_USE:    cfg_in.ways_in_use    = csr_data;
            default: ;
         endcase
      end
   end

   // Load the result register, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = way_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= sacl_pkg::ST_CLEAR;
         clr_ff                <= '0;
         rsp_valid_ff          <= 1'b0;
         cfg_ff.set_index_bits <= sacl_pkg::RST_SET_INDEX_BITS;
         cfg_ff.offset_bits    <= sacl_pkg::RST_OFFSET_BITS;
         cfg_ff.ways_in_use    <= sacl_pkg::RST_WAYS_IN_USE;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Request capture and set index
   sacl_index #(
      .SETS       (SETS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_index (
      .clock (clock),
      .load  (req_fire),
      .req   (req_data),
      .cfg   (cfg_ff),
      .cmd   (acc_cmd),
      .tag   (acc_tag),
      .set   (acc_set)
   );

   // Unpack the set row
   assign cur_tag   = row_rd[TAG_LO  +: WAYS * TW];
   assign cur_valid = row_rd[VAL_LO  +: WAYS];
   assign cur_occ   = row_rd[OCC_LO  +: WAYS];
   assign cur_rank  = row_rd[RANK_LO +: WAYS * RKW];

   // Way compare and LRU update
   sacl_ways #(
      .WAYS (WAYS),
      .TW   (TW),
      .RKW  (RKW)
   ) u_ways (
      .cur_tag     (cur_tag),
      .cur_valid   (cur_valid),
      .cur_occ     (cur_occ),
      .cur_rank    (cur_rank),
      .tag         (acc_tag),
      .cmd         (acc_cmd),
      .ways_in_use (cfg_ff.ways_in_use),
      .nxt_tag     (nxt_tag),
      .nxt_valid   (nxt_valid),
      .nxt_occ     (nxt_occ),
      .nxt_rank    (nxt_rank),
      .rsp         (way_rsp)
   );

   // Pack the row back; the sweep writes empty rows
   assign row_wr  = {nxt_rank, nxt_occ, nxt_valid, nxt_tag};
   assign wr_addr = clearing ? clr_ff : acc_set;
   assign wr_data = clearing ? '0 : row_wr;

   // Set RAM, one row per set
   sacl_ram #(
      .WIDTH (ROWW),
      .DEPTH (SETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (acc_set),
      .rd_data (row_rd)
   );

endmodule

`default_nettype wire

### sv/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [sacl_pkg::index_width(DEPTH)-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [sacl_pkg::index_width(DEPTH)-1:0]     rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/sacl_index.sv
// ----------------------------------------------------------------------------
// sacl_index
// Capture a request beat and derive its tag and set index, the set index
// reduced modulo the set count by a reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_index #(
   parameter int SETS       = sacl_pkg::DEF_SETS,
   parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
   input  wire logic                                          clock,
   input  wire logic                                          load,
   input  wire sacl_pkg::req_type                             req,
   input  wire sacl_pkg::cfg_type                             cfg,
   output      sacl_pkg::cmd_type                             cmd,
   output      logic [sacl_pkg::tag_width(ADDR_WIDTH)-1:0]    tag,
   output      logic [sacl_pkg::index_width(SETS)-1:0]        set
);

   localparam int TW    = sacl_pkg::tag_width(ADDR_WIDTH);
   localparam int SW    = sacl_pkg::index_width(SETS);
   localparam int IW    = sacl_pkg::IDX_W;
   localparam int SHW   = (TW > IW) ? TW : IW;
   localparam int RECIP = (2 ** IW) / SETS;
   localparam int RCW   = IW + 1;
   localparam int PW    = IW + RCW;
   localparam int SCW   = $clog2(SETS + 1);
   localparam int QW    = IW + SCW;
   localparam int RDW   = ((IW > SW) ? IW : SW) + 1;

   logic [TW-1:0]       adr;
   logic [SHW-1:0]      shifted;
   logic [IW-1:0]       idx_in;
   logic [PW-1:0]       prod;
   logic [IW-1:0]       q_in;
   logic [TW-1:0]       tag_in;

   sacl_pkg::cmd_type   cmd_ff;
   logic [TW-1:0]       tag_ff;
   logic [IW-1:0]       idx_ff;
   logic [IW-1:0]       q_ff;

   logic [QW-1:0]       qs;
   logic [IW-1:0]       rem;
   logic [RDW-1:0]      rem_ext;
   logic [RDW-1:0]      rem_fix;

   // Split the address: tag keeps the bits above the offset, index sits above it
   always_comb begin
      adr     = req.address[TW-1:0];
      tag_in  = adr & ({TW{1'b1}} << cfg.offset_bits);
      shifted = SHW'(adr) >> cfg.offset_bits;
      idx_in  = shifted[IW-1:0] & ~({IW{1'b1}} << cfg.set_index_bits);
      // quotient estimate, low by at most one
      prod    = PW'(idx_in) * PW'(RECIP);
      q_in    = prod[IW +: IW];
   end

   // Hold the beat for the read-modify-write
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= req.cmd;
         tag_ff <= tag_in;
         idx_ff <= idx_in;
         q_ff   <= q_in;
      end
   end

   // Remainder, then one compare and subtract
   always_comb begin
      qs      = QW'(q_ff) * QW'(SETS);
      rem     = idx_ff - qs[IW-1:0];
      rem_ext = RDW'(rem);
      if (rem_ext >= RDW'(SETS)) begin
         rem_fix = rem_ext - RDW'(SETS);
      end else begin
         rem_fix = rem_ext;
      end
   end

   assign cmd = cmd_ff;
   assign tag = tag_ff;
   assign set = rem_fix[SW-1:0];

endmodule

`default_nettype wire

### sv/sacl_ways.sv
// ----------------------------------------------------------------------------
// sacl_ways
// Compare all ways of one set, pick the hit or victim line and produce the
// updated set row together with the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ways #(
   parameter int WAYS = sacl_pkg::DEF_WAYS,
   parameter int TW   = sacl_pkg::DEF_ADDR_WIDTH,
   parameter int RKW  = sacl_pkg::index_width(sacl_pkg::DEF_WAYS)
) (
   input  wire logic [WAYS-1:0][TW-1:0]           cur_tag,
   input  wire logic [WAYS-1:0]                   cur_valid,
   input  wire logic [WAYS-1:0]                   cur_occ,
   input  wire logic [WAYS-1:0][RKW-1:0]          cur_rank,
   input  wire logic [TW-1:0]                     tag,
   input  wire sacl_pkg::cmd_type                 cmd,
   input  wire logic [sacl_pkg::CSR_W-1:0]        ways_in_use,
   output      logic [WAYS-1:0][TW-1:0]           nxt_tag,
   output      logic [WAYS-1:0]                   nxt_valid,
   output      logic [WAYS-1:0]                   nxt_occ,
   output      logic [WAYS-1:0][RKW-1:0]          nxt_rank,
   output      sacl_pkg::rsp_type                 rsp
);

   localparam int WIW = sacl_pkg::index_width(WAYS);
   localparam int CW  = $clog2(WAYS + 1);
   localparam int FW  = sacl_pkg::FIELD_W;

   logic [WAYS-1:0]   match;
   logic [WAYS-1:0]   hit_cand;
   logic [WAYS-1:0]   vic_cand;
   logic [WIW-1:0]    hit_idx;
   logic [WIW-1:0]    vic_idx;
   logic [WIW-1:0]    free_idx;
   logic              hit_any;
   logic              vic_any;
   logic              free_any;
   logic [CW-1:0]     fill;
   logic [CW-1:0]     limit;
   logic              full;

   // Tag compare on occupied ways; invalid lines still match
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         match[i] = cur_occ[i] && (cur_tag[i] == tag);
      end
   end

   // Keep only the oldest matching way and the oldest occupied way
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         hit_cand[i] = match[i];
         vic_cand[i] = cur_occ[i];
         for (int j = 0; j < WAYS; j++) begin
            if (match[j] && (cur_rank[j] > cur_rank[i])) begin
               hit_cand[i] = 1'b0;
            end
            if (cur_occ[j] && (cur_rank[j] > cur_rank[i])) begin
               vic_cand[i] = 1'b0;
            end
         end
      end
   end

   // Lowest index wins a tie
   always_comb begin
      hit_idx  = '0;
      vic_idx  = '0;
      free_idx = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (hit_cand[i]) begin
            hit_idx = WIW'(i);
         end
         if (vic_cand[i]) begin
            vic_idx = WIW'(i);
         end
         if (!cur_occ[i]) begin
            free_idx = WIW'(i);
         end
      end
      hit_any  = |match;
      vic_any  = |cur_occ;
      free_any = ~&cur_occ;
   end

   // Count occupied ways and clamp the associativity limit
   always_comb begin
      fill = '0;
      for (int i = 0; i < WAYS; i++) begin
         fill = fill + CW'(cur_occ[i]);
      end
      if (ways_in_use == '0) begin
         limit = CW'(1);
      end else if (int'(ways_in_use) > WAYS) begin
         limit = CW'(WAYS);
      end else begin
         limit = CW'(ways_in_use);
      end
      full = (fill >= limit);
   end

   // Build the new row and the result beat
   always_comb begin
      logic [RKW-1:0] hr;
      logic [WIW-1:0] w;
      nxt_tag        = cur_tag;
      nxt_valid      = cur_valid;
      nxt_occ        = cur_occ;
      nxt_rank       = cur_rank;
      rsp.outcome    = sacl_pkg::OUT_RD_MISS;
      rsp.line_tag   = '0;
      rsp.line_valid = 1'b0;
      hr             = cur_rank[hit_idx];
      w              = '0;
      if (hit_any) begin
         // age the ways younger than the hit, hit becomes most recent
         for (int i = 0; i < WAYS; i++) begin
            if ((WIW'(i) != hit_idx) && cur_occ[i] && (cur_rank[i] < hr)) begin
               nxt_rank[i] = cur_rank[i] + 1'b1;
            end
         end
         nxt_rank[hit_idx] = '0;
         rsp.line_tag      = FW'(cur_tag[hit_idx]);
         if (cmd == sacl_pkg::CMD_WRITE) begin
            nxt_valid[hit_idx] = 1'b0;
            rsp.outcome        = sacl_pkg::OUT_WR_HIT;
            rsp.line_valid     = 1'b0;
         end else begin
            rsp.outcome        = sacl_pkg::OUT_RD_HIT;
            rsp.line_valid     = cur_valid[hit_idx];
         end
      end else if (cmd == sacl_pkg::CMD_WRITE) begin
         // evict the oldest line when full, else take a free way
         if (full && vic_any) begin
            w            = vic_idx;
            rsp.outcome  = sacl_pkg::OUT_WR_EVICT;
            rsp.line_tag = FW'(cur_tag[vic_idx]);
         end else begin
            w            = free_any ? free_idx : '0;
            rsp.outcome  = sacl_pkg::OUT_WR_MISS;
         end
         for (int i = 0; i < WAYS; i++) begin
            if ((WIW'(i) != w) && cur_occ[i]) begin
               nxt_rank[i] = cur_rank[i] + 1'b1;
            end
         end
         nxt_tag[w]   = tag;
         nxt_valid[w] = 1'b1;
         nxt_occ[w]   = 1'b1;
         nxt_rank[w]  = '0;
      end
   end

endmodule

`default_nettype wire

### sv/sacl_checker.sv
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks on the tag store, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_cache_lru_tags_assert.svh"

module sacl_checker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire sacl_pkg::rsp_type    rsp_data
);

   // A waiting result beat holds
   `SACL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

   // No request beat right after reset, at the start of the clearing pass
   `SACL_ASSERT_IMP(a_clear_blocks, clock, reset, $past(reset), !req_ready, "request taken during clearing pass")

   // One access at a time: the cycle after a request beat takes none
   `SACL_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken during row read")

   // Misses without eviction report no line
   `SACL_ASSERT_IMP(a_miss_empty, clock, reset, rsp_valid && (rsp_data.outcome == sacl_pkg::OUT_RD_MISS || rsp_data.outcome == sacl_pkg::OUT_WR_MISS), (rsp_data.line_tag == '0) && !rsp_data.line_valid, "miss reports a line")

   // Write hits and evictions leave the returned line invalid
   `SACL_ASSERT_IMP(a_write_invalid, clock, reset, rsp_valid && (rsp_data.outcome == sacl_pkg::OUT_WR_HIT || rsp_data.outcome == sacl_pkg::OUT_WR_EVICT), !rsp_data.line_valid, "returned line still valid")

endmodule

bind set_assoc_cache_lru_tags sacl_checker u_sacl_checker (.*);

`default_nettype wire

### verif/tb_set_assoc_cache_lru_tags.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_tags
// Self-checking bench for the set-associative LRU tag store. A short
// table of directed accesses and register writes comes first, then
// random phases under several geometries. Every access is predicted by
// an in-bench tag store model, and each result beat is compared field by
// field with the oldest prediction. Both channels stall at random.
// ----------------------------------------------------------------------------

module tb_set_assoc_cache_lru_tags;

   localparam int NWAYS        = sacl_pkg::DEF_WAYS;
   localparam int NSETS        = sacl_pkg::DEF_SETS;
   localparam int PHASE_ITEMS  = 200;
   localparam int HOLD_AT_RSP  = 700;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 10;

   // register index with no register behind it
   localparam logic [sacl_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef enum logic {
      ROW_ACCESS,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      sacl_pkg::cmd_type              cmd;
      logic [sacl_pkg::FIELD_W-1:0]   address;
      logic [sacl_pkg::CSR_IDX_W-1:0] reg_idx;
      logic [sacl_pkg::CSR_W-1:0]     reg_val;
      logic                           typed;
      sacl_pkg::rsp_type              want;
   } row_type;

   localparam sacl_pkg::rsp_type NO_RSP = '0;

   // Directed script: typed results only where they are obvious
   localparam int DIRECTED_ROWS = 26;
   localparam row_type DIRECTED [DIRECTED_ROWS] = '{
      // empty store after reset, fill and hit one line in set 0
      '{ROW_ACCESS, sacl_pkg::CMD_READ,  32'h0000_0000, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_RD_MISS, 32'h0, 1'b0}},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'h0000_0000, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_WR_MISS, 32'h0, 1'b0}},
      '{ROW_ACCESS, sacl_pkg::CMD_READ,  32'h0000_003F, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_RD_HIT, 32'h0, 1'b1}},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'h0000_0010, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_WR_HIT, 32'h0, 1'b0}},
      // a line with its valid mark cleared still hits
      '{ROW_ACCESS, sacl_pkg::CMD_READ,  32'h0000_0000, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_RD_HIT, 32'h0, 1'b0}},
      // top of the address range
      '{ROW_ACCESS, sacl_pkg::CMD_READ,  32'hFFFF_FFFF, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_RD_MISS, 32'h0, 1'b0}},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'hFFFF_FFFF, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_WR_MISS, 32'h0, 1'b0}},
      '{ROW_ACCESS, sacl_pkg::CMD_READ,  32'hFFFF_FFC0, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_RD_HIT, 32'hFFFF_FFC0, 1'b1}},
      // zero associativity acts as one way
      '{ROW_CSR,    sacl_pkg::CMD_READ,  32'h0, sacl_pkg::CSR_WAYS_IN_USE, 4'd0,
        1'b0, NO_RSP},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'h0001_0140, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_WR_MISS, 32'h0, 1'b0}},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'h0002_0140, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b1, '{sacl_pkg::OUT_WR_EVICT, 32'h0001_0140, 1'b0}},
      // associativity above the way count acts as all ways
      '{ROW_CSR,    sacl_pkg::CMD_READ,  32'h0, sacl_pkg::CSR_WAYS_IN_USE, 4'd15,
        1'b0, NO_RSP},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'h0003_0140, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b0, NO_RSP},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'h0004_0140, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b0, NO_RSP},
      '{ROW_ACCESS, sacl_pkg::CMD_READ,  32'h0002_0140, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b0, NO_RSP},
      // lowered associativity with a set filled above it
      '{ROW_CSR,    sacl_pkg::CMD_READ,  32'h0, sacl_pkg::CSR_WAYS_IN_USE, 4'd2,
        1'b0, NO_RSP},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'h0005_0140, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b0, NO_RSP},
      // set index wider than the set count wraps
      '{ROW_CSR,    sacl_pkg::CMD_READ,  32'h0, sacl_pkg::CSR_SET_INDEX_BITS, 4'd15,
        1'b0, NO_RSP},
      '{ROW_CSR,    sacl_pkg::CMD_READ,  32'h0, sacl_pkg::CSR_OFFSET_BITS, 4'd0,
        1'b0, NO_RSP},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'h0000_0400, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b0, NO_RSP},
      '{ROW_ACCESS, sacl_pkg::CMD_READ,  32'h0000_0000, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b0, NO_RSP},
      // single set, wide lines: stored tags now overlap
      '{ROW_CSR,    sacl_pkg::CMD_READ,  32'h0, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b0, NO_RSP},
      '{ROW_CSR,    sacl_pkg::CMD_READ,  32'h0, sacl_pkg::CSR_OFFSET_BITS, 4'd12,
        1'b0, NO_RSP},
      '{ROW_ACCESS, sacl_pkg::CMD_READ,  32'h0000_0400, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b0, NO_RSP},
      '{ROW_CSR,    sacl_pkg::CMD_READ,  32'h0, CSR_UNUSED_IDX, 4'd15,
        1'b0, NO_RSP},
      '{ROW_ACCESS, sacl_pkg::CMD_WRITE, 32'hFFFF_FFFF, sacl_pkg::CSR_SET_INDEX_BITS, 4'd0,
        1'b0, NO_RSP}
   };

   // Random phases: reset geometry, extremes, and a spread in between
   localparam int PHASES = 10;
   localparam sacl_pkg::cfg_type PHASE_CFG [PHASES] = '{
      '{4'd10, 4'd6,  4'd8},
      '{4'd0,  4'd0,  4'd1},
      '{4'd15, 4'd15, 4'd15},
      '{4'd3,  4'd4,  4'd2},
      '{4'd10, 4'd12, 4'd4},
      '{4'd1,  4'd2,  4'd8},
      '{4'd5,  4'd0,  4'd0},
      '{4'd8,  4'd3,  4'd3},
      '{4'd12, 4'd1,  4'd6},
      '{4'd2,  4'd8,  4'd5}
   };

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_valid  = 1'b0;
   logic                           req_ready;
   sacl_pkg::req_type              req_data   = '0;
   logic                           rsp_valid;
   logic                           rsp_ready  = 1'b0;
   sacl_pkg::rsp_type              rsp_data;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [sacl_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [sacl_pkg::CSR_W-1:0]     csr_data   = '0;

   // Tag store mirror, entry for way w of set s at s*NWAYS+w
   bit [sacl_pkg::FIELD_W-1:0] line_tag_mem   [NSETS*NWAYS];
   bit                         line_valid_mem [NSETS*NWAYS];
   bit                         line_held_mem  [NSETS*NWAYS];
   int                         line_age_mem   [NSETS*NWAYS];
   int                         set_fill_mem   [NSETS];

   logic [sacl_pkg::CSR_W-1:0] cur_index_bits  = sacl_pkg::RST_SET_INDEX_BITS;
   logic [sacl_pkg::CSR_W-1:0] cur_offset_bits = sacl_pkg::RST_OFFSET_BITS;
   logic [sacl_pkg::CSR_W-1:0] cur_ways        = sacl_pkg::RST_WAYS_IN_USE;

   sacl_pkg::rsp_type awaited_rsp [$];
   int      fail_count = 0;
   int      rsp_count  = 0;
   int      send_quiet = 0;

   set_assoc_cache_lru_tags dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock and reset
   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   // Age held ways below lim_rank (all if fresh) by one, make w most recent
   function automatic void make_recent(int base, int w, int lim_rank, bit fresh);
      for (int i = 0; i < NWAYS; i++) begin
         if (i != w && line_held_mem[base+i] && (fresh || line_age_mem[base+i] < lim_rank))
            line_age_mem[base+i] = line_age_mem[base+i] + 1;
      end
      line_age_mem[base+w] = 0;
   endfunction

   // Look up one access in the mirror, update it, return the result beat
   function automatic sacl_pkg::rsp_type tag_lookup(sacl_pkg::req_type acc);
      sacl_pkg::rsp_type            res;
      logic [sacl_pkg::FIELD_W-1:0] tag;
      logic [sacl_pkg::FIELD_W-1:0] idx;
      int               set_no;
      int               base;
      int               lim;
      int               hit_w;
      int               old_w;
      int               free_w;
      int               w;
      int               e;
      tag    = acc.address & ~((32'd1 << cur_offset_bits) - 32'd1);
      idx    = (acc.address >> cur_offset_bits) & ((32'd1 << cur_index_bits) - 32'd1);
      set_no = int'(idx % NSETS);
      base   = set_no * NWAYS;
      lim    = int'(cur_ways);
      if (lim < 1) lim = 1;
      if (lim > NWAYS) lim = NWAYS;
      hit_w  = NWAYS;
      old_w  = NWAYS;
      free_w = NWAYS;
      res    = NO_RSP;

      // scan held ways: oldest tag match, oldest line, first free way
      for (int i = 0; i < NWAYS; i++) begin
         e = base + i;
         if (line_held_mem[e]) begin
            if (line_tag_mem[e] == tag &&
                (hit_w == NWAYS || line_age_mem[e] > line_age_mem[base+hit_w]))
               hit_w = i;
            if (old_w == NWAYS || line_age_mem[e] > line_age_mem[base+old_w])
               old_w = i;
         end else if (free_w == NWAYS) begin
            free_w = i;
         end
      end

      if (hit_w != NWAYS) begin
         e = base + hit_w;
         if (acc.cmd == sacl_pkg::CMD_WRITE) line_valid_mem[e] = 1'b0;
         make_recent(base, hit_w, line_age_mem[e], 1'b0);
         res.outcome    = (acc.cmd == sacl_pkg::CMD_WRITE) ? sacl_pkg::OUT_WR_HIT
                                                           : sacl_pkg::OUT_RD_HIT;
         res.line_tag   = line_tag_mem[e];
         res.line_valid = line_valid_mem[e];
      end else if (acc.cmd == sacl_pkg::CMD_READ) begin
         res.outcome = sacl_pkg::OUT_RD_MISS;
      end else begin
         // write miss: evict the oldest line once the set is at its limit
         if (set_fill_mem[set_no] >= lim && old_w != NWAYS) begin
            w = old_w;
            res.outcome  = sacl_pkg::OUT_WR_EVICT;
            res.line_tag = line_tag_mem[base+w];
            line_held_mem[base+w] = 1'b0;
         end else begin
            w = free_w;
            set_fill_mem[set_no] = set_fill_mem[set_no] + 1;
            res.outcome = sacl_pkg::OUT_WR_MISS;
         end
         if (w >= NWAYS) w = 0;
         make_recent(base, w, 0, 1'b1);
         line_tag_mem[base+w]   = tag;
         line_valid_mem[base+w] = 1'b1;
         line_held_mem[base+w]  = 1'b1;
         line_age_mem[base+w]   = 0;
      end
      return res;
   endfunction

   // Gap length in cycles: mostly short, a few long, with quiet stretches
   function automatic int pick_gap(inout int quiet_left);
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         quiet_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one access beat, predict it on acceptance, then idle for the gap
   task automatic send_access(sacl_pkg::req_type acc, logic typed, sacl_pkg::rsp_type want,
                              int gap);
      sacl_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= acc;
      do @(posedge clock); while (!req_ready);
      predicted = tag_lookup(acc);
      awaited_rsp.push_back(typed ? want : predicted);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Write one register once every pending result has come back
   task automatic write_reg(logic [sacl_pkg::CSR_IDX_W-1:0] idx,
                            logic [sacl_pkg::CSR_W-1:0] val);
      while (awaited_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sacl_pkg::CSR_SET_INDEX_BITS: cur_index_bits  = val;
         sacl_pkg::CSR_OFFSET_BITS:    cur_offset_bits = val;
         sacl_pkg::CSR_WAYS_IN_USE:    cur_ways        = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stimulus: directed script, then random phases, then drain
   initial begin : stimulus
      sacl_pkg::req_type            acc;
      int                           gap;
      int                           pool_n;
      int                           r;
      logic [sacl_pkg::FIELD_W-1:0] line_pool [64];
      logic [sacl_pkg::FIELD_W-1:0] off_mask;
      logic [sacl_pkg::FIELD_W-1:0] set_mask;
      while (reset) @(negedge clock);

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
         end else begin
            acc.cmd     = DIRECTED[i].cmd;
            acc.address = DIRECTED[i].address;
            gap = pick_gap(send_quiet);
            // drop valid before a register write and at the end of the script
            if (gap == 0 && (i == DIRECTED_ROWS-1 || DIRECTED[i+1].kind == ROW_CSR))
               gap = 1;
            send_access(acc, DIRECTED[i].typed, DIRECTED[i].want, gap);
         end
      end

      foreach (PHASE_CFG[p]) begin
         write_reg(sacl_pkg::CSR_SET_INDEX_BITS, PHASE_CFG[p].set_index_bits);
         write_reg(sacl_pkg::CSR_OFFSET_BITS, PHASE_CFG[p].offset_bits);
         write_reg(sacl_pkg::CSR_WAYS_IN_USE, PHASE_CFG[p].ways_in_use);

         // build a pool of lines crowded into a few sets
         off_mask = (32'd1 << PHASE_CFG[p].offset_bits) - 32'd1;
         set_mask = ((32'd1 << PHASE_CFG[p].set_index_bits) - 32'd1)
                    << PHASE_CFG[p].offset_bits;
         pool_n = $urandom_range(6, 40);
         for (int k = 0; k < pool_n; k++)
            line_pool[k] = ($urandom & ~set_mask & ~off_mask) |
                           ((32'($urandom_range(0, 3)) << PHASE_CFG[p].offset_bits)
                            & set_mask);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               acc.address = line_pool[$urandom_range(0, pool_n-1)] | ($urandom & off_mask);
            else if (r < 90)
               acc.address = line_pool[$urandom_range(0, pool_n-1)];
            else
               acc.address = $urandom;
            acc.cmd = sacl_pkg::cmd_type'($urandom_range(0, 1));
            gap = pick_gap(send_quiet);
            if (gap == 0 && n == PHASE_ITEMS-1) gap = 1;
            send_access(acc, 1'b0, NO_RSP, gap);
         end
      end

      // drain, then give stray beats a chance to show up
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Result side ready: random stalls, one long hold once traffic is flowing
   initial begin : rsp_side
      int stall_left;
      int quiet;
      bit held;
      stall_left = 0;
      quiet      = 0;
      held       = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_count >= HOLD_AT_RSP) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap(quiet);
         end
      end
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin : rsp_check
      sacl_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (awaited_rsp.size() == 0) begin
            $error("result beat with nothing pending: outcome %0d tag %h valid %0d",
                   rsp_data.outcome, rsp_data.line_tag, rsp_data.line_valid);
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.outcome !== want.outcome) begin
               $error("outcome: expected %0d, actual %0d", want.outcome, rsp_data.outcome);
               fail_count++;
            end
            if (rsp_data.line_tag !== want.line_tag) begin
               $error("line_tag: expected %h, actual %h", want.line_tag, rsp_data.line_tag);
               fail_count++;
            end
            if (rsp_data.line_valid !== want.line_valid) begin
               $error("line_valid: expected %0d, actual %0d",
                      want.line_valid, rsp_data.line_valid);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles with no beat on any channel
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule
